/* rtl/pngcsc_pkg.sv */
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// pngcsc_pkg
// Shared types, constants and CRC/decode helpers for the PNG chunk checker.
// ---------------------------------------------------------------------------
package pngcsc_pkg;

    localparam int unsigned IN_DATA_W  = 8;
    localparam int unsigned IN_USER_W  = 1;
    localparam int unsigned OUT_DATA_W = 184;
    localparam int unsigned OUT_USER_W = 5;

    localparam logic [31:0] CRC_POLY   = 32'hEDB8_8320;
    localparam logic [31:0] CRC_INIT   = 32'hFFFF_FFFF;

    localparam logic [31:0] TYPE_IHDR  = 32'h4948_4452;
    localparam logic [31:0] TYPE_PLTE  = 32'h504C_5445;
    localparam logic [31:0] TYPE_TRNS  = 32'h7452_4E53;
    localparam logic [31:0] TYPE_IDAT  = 32'h4944_4154;
    localparam logic [31:0] TYPE_IEND  = 32'h4945_4E44;

    localparam logic [7:0] SIG_BYTES [8] = '{8'd137, 8'd80, 8'd78, 8'd71,
                                             8'd13, 8'd10, 8'd26, 8'd10};

    typedef enum logic [2:0] {
        PH_SIG,
        PH_LEN,
        PH_TYPE,
        PH_DATA,
        PH_CRC
    } phase_t;

    typedef enum logic [1:0] {
        EV_CHUNK = 2'd0,
        EV_END   = 2'd1,
        EV_ERROR = 2'd2
    } event_t;

    typedef enum logic [2:0] {
        KIND_IHDR  = 3'd0,
        KIND_PLTE  = 3'd1,
        KIND_TRNS  = 3'd2,
        KIND_IDAT  = 3'd3,
        KIND_IEND  = 3'd4,
        KIND_OTHER = 3'd5
    } kind_t;

    typedef enum logic [2:0] {
        ERR_NONE      = 3'd0,
        ERR_SIGNATURE = 3'd1,
        ERR_CRC       = 3'd2,
        ERR_DUPLICATE = 3'd3,
        ERR_FORMAT    = 3'd4,
        ERR_ORDER     = 3'd5
    } err_t;

    // One byte of reflected CRC-32, LSB first.
    function automatic logic [31:0] crc32_byte(input logic [31:0] crc,
                                               input logic [7:0]  data);
        logic [31:0] c;
        c = crc ^ {24'd0, data};
        for (int i = 0; i < 8; i++) begin
            c = c[0] ? ((c >> 1) ^ CRC_POLY) : (c >> 1);
        end
        return c;
    endfunction

    function automatic kind_t kind_of(input logic [31:0] chunk_type);
        kind_t k;
        k = KIND_OTHER;
        if (chunk_type == TYPE_IHDR) begin
            k = KIND_IHDR;
        end else if (chunk_type == TYPE_PLTE) begin
            k = KIND_PLTE;
        end else if (chunk_type == TYPE_TRNS) begin
            k = KIND_TRNS;
        end else if (chunk_type == TYPE_IDAT) begin
            k = KIND_IDAT;
        end else if (chunk_type == TYPE_IEND) begin
            k = KIND_IEND;
        end
        return k;
    endfunction

    // hdr_fmt: [7:0] depth, [15:8] colour type, [16] any method byte nonzero
    function automatic logic format_ok(input logic [16:0] hdr_fmt);
        logic ok;
        ok = 1'b0;
        if (!hdr_fmt[16]) begin
            if (hdr_fmt[7:0] == 8'd8) begin
                ok = (hdr_fmt[15:8] == 8'd0) || (hdr_fmt[15:8] == 8'd2) ||
                     (hdr_fmt[15:8] == 8'd3) || (hdr_fmt[15:8] == 8'd4) ||
                     (hdr_fmt[15:8] == 8'd6);
            end else if (hdr_fmt[7:0] == 8'd16) begin
                ok = (hdr_fmt[15:8] == 8'd0) || (hdr_fmt[15:8] == 8'd2) ||
                     (hdr_fmt[15:8] == 8'd4) || (hdr_fmt[15:8] == 8'd6);
            end
        end
        return ok;
    endfunction

endpackage

/* rtl/png_chunk_stream_checker.sv */
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// png_chunk_stream_checker
// Byte-wise PNG signature check, chunk framing, CRC-32 check and header
// capture; one result beat per finished chunk or error.
// ---------------------------------------------------------------------------
//  channel  | direction | payload
//  s_       | in        | tdata: stream_byte[7:0]; tuser: file_start[0]
//  m_       | out       | tdata: body_len, error_code, image_width,
//           |           |   image_height, bit_depth, colour_type, output_size
//           |           | tuser: event_res, chunk_kind
//
// One byte per cycle while the output slot is free; a byte's result appears on m_ the cycle
// after it is accepted. The byte CRC update and field capture sit between
// the state registers and the result register.
// Reset (aresetn low, synchronous) leaves the block halted: bytes are
// dropped until one arrives with file_start set.
// s_tready drops only while a result beat is held and m_tready is low.
// output_size comes from a registered 32x32 multiply of the header regs;
// the CRC bytes of a chunk lie between the last header byte and any result.
// ---------------------------------------------------------------------------
module png_chunk_stream_checker (
    input  logic                               aclk,
    input  logic                               aresetn,
    input  logic                               s_tvalid,
    output logic                               s_tready,
    input  logic [pngcsc_pkg::IN_DATA_W-1:0]   s_tdata,  // [7:0] stream_byte
    input  logic [pngcsc_pkg::IN_USER_W-1:0]   s_tuser,  // [0] file_start
    output logic                               m_tvalid,
    input  logic                               m_tready,
    // [31:0] body_len, [34:32] error_code, [66:35] image_width,
    // [98:67] image_height, [106:99] bit_depth, [114:107] colour_type,
    // [178:115] output_size, [183:179] zero
    output logic [pngcsc_pkg::OUT_DATA_W-1:0]  m_tdata,
    // [1:0] event_res, [4:2] chunk_kind
    output logic [pngcsc_pkg::OUT_USER_W-1:0]  m_tuser
);
    import pngcsc_pkg::*;

    // parser state
    phase_t      phase_reg,   phase_next;
    logic [2:0]  pos_reg,     pos_next;
    logic        sig_bad_reg, sig_bad_next;
    logic [31:0] len_reg,     len_next;
    logic [31:0] rem_reg,     rem_next;
    logic [31:0] type_reg,    type_next;
    logic [31:0] crc_reg,     crc_next;
    logic [31:0] rcv_reg,     rcv_next;
    logic [2:0]  seen_reg,    seen_next;
    logic [31:0] hw_reg,      hw_next;
    logic [31:0] hh_reg,      hh_next;
    logic [16:0] hf_reg,      hf_next;
    logic        halted_reg,  halted_next;

    // effective state after a possible file restart
    phase_t      cur_phase;
    logic [2:0]  cur_pos;
    logic        cur_sig_bad;
    logic [31:0] cur_len, cur_rem, cur_type, cur_crc, cur_rcv;
    logic [2:0]  cur_seen;
    logic [31:0] cur_hw, cur_hh;
    logic [16:0] cur_hf;
    logic        cur_halted;

    // result register
    logic        m_tvalid_reg;
    event_t      ev_reg;
    kind_t       kind_reg;
    logic [31:0] rlen_reg;
    err_t        err_reg;
    logic [31:0] rw_reg, rh_reg;
    logic [7:0]  rdepth_reg, rcolour_reg;
    logic [63:0] rsize_reg;

    logic        s_accept;
    logic        file_start;
    logic [7:0]  in_byte;
    logic [31:0] crc_step;
    logic [31:0] len_shift;
    logic [31:0] rcv_shift;
    logic [31:0] data_idx;
    logic [31:0] rem_dec;
    logic        sig_bad_new;
    kind_t       cur_kind;
    logic [2:0]  seen_bit;
    logic        crc_ok;
    logic [63:0] size_val;

    logic        res_emit;
    event_t      res_ev;
    kind_t       res_kind;
    logic [31:0] res_len;
    err_t        res_err;

    assign in_byte    = s_tdata[7:0];
    assign file_start = s_tuser[0];
    assign s_tready   = !m_tvalid_reg || m_tready;
    assign s_accept   = s_tvalid && s_tready;

    pngcsc_size_calc u_size (
        .aclk       (aclk),
        .img_width  (hw_reg),
        .img_height (hh_reg),
        .out_size   (size_val)
    );

    // file_start clears per-file state before the byte is parsed
    always_comb begin
        if (file_start) begin
            cur_phase   = PH_SIG;
            cur_pos     = 3'd0;
            cur_sig_bad = 1'b0;
            cur_len     = 32'd0;
            cur_rem     = 32'd0;
            cur_type    = 32'd0;
            cur_crc     = CRC_INIT;
            cur_rcv     = 32'd0;
            cur_seen    = 3'd0;
            cur_hw      = 32'd0;
            cur_hh      = 32'd0;
            cur_hf      = 17'd0;
            cur_halted  = 1'b0;
        end else begin
            cur_phase   = phase_reg;
            cur_pos     = pos_reg;
            cur_sig_bad = sig_bad_reg;
            cur_len     = len_reg;
            cur_rem     = rem_reg;
            cur_type    = type_reg;
            cur_crc     = crc_reg;
            cur_rcv     = rcv_reg;
            cur_seen    = seen_reg;
            cur_hw      = hw_reg;
            cur_hh      = hh_reg;
            cur_hf      = hf_reg;
            cur_halted  = halted_reg;
        end
    end

    assign crc_step    = crc32_byte(cur_crc, in_byte);
    assign len_shift   = {cur_len[23:0], in_byte};
    assign rcv_shift   = {cur_rcv[23:0], in_byte};
    assign data_idx    = cur_len - cur_rem;
    assign rem_dec     = cur_rem - 32'd1;
    assign sig_bad_new = cur_sig_bad || (in_byte != SIG_BYTES[cur_pos]);
    assign cur_kind    = kind_of(cur_type);
    assign crc_ok      = ((cur_crc ^ CRC_INIT) == rcv_shift);

    always_comb begin
        case (cur_kind)
            KIND_IHDR: seen_bit = 3'b001;
            KIND_PLTE: seen_bit = 3'b010;
            KIND_TRNS: seen_bit = 3'b100;
            default:   seen_bit = 3'b000;
        endcase
    end

    // result decode
    always_comb begin
        res_emit = 1'b0;
        res_ev   = EV_CHUNK;
        res_kind = cur_kind;
        res_len  = cur_len;
        res_err  = ERR_NONE;
        if (s_accept && !cur_halted) begin
            unique case (cur_phase)
                PH_SIG: begin
                    if ((cur_pos == 3'd7) && sig_bad_new) begin
                        res_emit = 1'b1;
                        res_ev   = EV_ERROR;
                        res_kind = KIND_IHDR;
                        res_len  = 32'd0;
                        res_err  = ERR_SIGNATURE;
                    end
                end
                PH_CRC: begin
                    if (cur_pos == 3'd3) begin
                        res_emit = 1'b1;
                        if (!crc_ok) begin
                            res_ev  = EV_ERROR;
                            res_err = ERR_CRC;
                        end else if ((seen_bit & cur_seen) != 3'd0) begin
                            res_ev  = EV_ERROR;
                            res_err = ERR_DUPLICATE;
                        end else if ((cur_kind == KIND_IDAT) && !cur_seen[0]) begin
                            res_ev  = EV_ERROR;
                            res_err = ERR_ORDER;
                        end else if ((cur_kind == KIND_IDAT) && !format_ok(cur_hf)) begin
                            res_ev  = EV_ERROR;
                            res_err = ERR_FORMAT;
                        end else if (cur_kind == KIND_IEND) begin
                            res_ev  = EV_END;
                        end
                    end
                end
                default: begin
                end
            endcase
        end
    end

    // next state
    always_comb begin
        phase_next   = phase_reg;
        pos_next     = pos_reg;
        sig_bad_next = sig_bad_reg;
        len_next     = len_reg;
        rem_next     = rem_reg;
        type_next    = type_reg;
        crc_next     = crc_reg;
        rcv_next     = rcv_reg;
        seen_next    = seen_reg;
        hw_next      = hw_reg;
        hh_next      = hh_reg;
        hf_next      = hf_reg;
        halted_next  = halted_reg;
        if (s_accept) begin
            phase_next   = cur_phase;
            pos_next     = cur_pos;
            sig_bad_next = cur_sig_bad;
            len_next     = cur_len;
            rem_next     = cur_rem;
            type_next    = cur_type;
            crc_next     = cur_crc;
            rcv_next     = cur_rcv;
            seen_next    = cur_seen;
            hw_next      = cur_hw;
            hh_next      = cur_hh;
            hf_next      = cur_hf;
            halted_next  = cur_halted;
            if (!cur_halted) begin
                unique case (cur_phase)
                    PH_SIG: begin
                        sig_bad_next = sig_bad_new;
                        pos_next     = cur_pos + 3'd1;
                        if (cur_pos == 3'd7) begin
                            if (sig_bad_new) begin
                                halted_next = 1'b1;
                            end else begin
                                phase_next = PH_LEN;
                            end
                        end
                    end
                    PH_LEN: begin
                        len_next = len_shift;
                        pos_next = cur_pos + 3'd1;
                        if (cur_pos == 3'd3) begin
                            pos_next   = 3'd0;
                            rem_next   = len_shift;
                            crc_next   = CRC_INIT;
                            phase_next = PH_TYPE;
                        end
                    end
                    PH_TYPE: begin
                        type_next = {cur_type[23:0], in_byte};
                        crc_next  = crc_step;
                        pos_next  = cur_pos + 3'd1;
                        if (cur_pos == 3'd3) begin
                            pos_next   = 3'd0;
                            phase_next = (cur_rem != 32'd0) ? PH_DATA : PH_CRC;
                        end
                    end
                    PH_DATA: begin
                        crc_next = crc_step;
                        rem_next = rem_dec;
                        // header fields from the first IHDR only
                        if ((cur_type == TYPE_IHDR) && !cur_seen[0] &&
                            (data_idx[31:4] == 28'd0)) begin
                            case (data_idx[3:0]) inside
                                [4'd0:4'd3]:  hw_next = {cur_hw[23:0], in_byte};
                                [4'd4:4'd7]:  hh_next = {cur_hh[23:0], in_byte};
                                4'd8:         hf_next[7:0]  = in_byte;
                                4'd9:         hf_next[15:8] = in_byte;
                                [4'd10:4'd12]: begin
                                    if (in_byte != 8'd0) begin
                                        hf_next[16] = 1'b1;
                                    end
                                end
                                default: begin
                                end
                            endcase
                        end
                        if (rem_dec == 32'd0) begin
                            pos_next   = 3'd0;
                            phase_next = PH_CRC;
                        end
                    end
                    PH_CRC: begin
                        rcv_next = rcv_shift;
                        pos_next = cur_pos + 3'd1;
                        if (cur_pos == 3'd3) begin
                            pos_next = 3'd0;
                            if (res_ev != EV_CHUNK) begin
                                halted_next = 1'b1;
                            end else begin
                                phase_next = PH_LEN;
                                crc_next   = CRC_INIT;
                                seen_next  = cur_seen | seen_bit;
                            end
                        end
                    end
                    default: begin
                        phase_next  = PH_SIG;
                        halted_next = 1'b1;
                    end
                endcase
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg    <= PH_SIG;
            pos_reg      <= 3'd0;
            sig_bad_reg  <= 1'b0;
            len_reg      <= 32'd0;
            rem_reg      <= 32'd0;
            type_reg     <= 32'd0;
            crc_reg      <= CRC_INIT;
            rcv_reg      <= 32'd0;
            seen_reg     <= 3'd0;
            hw_reg       <= 32'd0;
            hh_reg       <= 32'd0;
            hf_reg       <= 17'd0;
            halted_reg   <= 1'b1;
            m_tvalid_reg <= 1'b0;
        end else begin
            phase_reg    <= phase_next;
            pos_reg      <= pos_next;
            sig_bad_reg  <= sig_bad_next;
            len_reg      <= len_next;
            rem_reg      <= rem_next;
            type_reg     <= type_next;
            crc_reg      <= crc_next;
            rcv_reg      <= rcv_next;
            seen_reg     <= seen_next;
            hw_reg       <= hw_next;
            hh_reg       <= hh_next;
            hf_reg       <= hf_next;
            halted_reg   <= halted_next;
            if (res_emit) begin
                m_tvalid_reg <= 1'b1;
            end else if (m_tready) begin
                m_tvalid_reg <= 1'b0;
            end
        end
    end

    // result payload; header values are steady at any result beat
    always_ff @(posedge aclk) begin
        if (res_emit) begin
            ev_reg      <= res_ev;
            kind_reg    <= res_kind;
            rlen_reg    <= res_len;
            err_reg     <= res_err;
            rw_reg      <= cur_hw;
            rh_reg      <= cur_hh;
            rdepth_reg  <= cur_hf[7:0];
            rcolour_reg <= cur_hf[15:8];
            rsize_reg   <= size_val;
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = {5'd0, rsize_reg, rcolour_reg, rdepth_reg, rh_reg, rw_reg,
                       err_reg, rlen_reg};
    assign m_tuser  = {kind_reg, ev_reg};

`ifndef SYNTHESIS
    // once halted, only a file start revives the parser
    assert property (@(posedge aclk) disable iff (!aresetn)
        (halted_reg && !(s_accept && file_start)) |=> halted_reg)
        else $error("parser left halt without file start");

    // error and end results stop the parser
    assert property (@(posedge aclk) disable iff (!aresetn)
        (res_emit && (res_ev != EV_CHUNK)) |=> halted_reg)
        else $error("parser kept running after error or end");

    // an error beat always carries a code, other beats never do
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid_reg |-> ((ev_reg == EV_ERROR) == (err_reg != ERR_NONE)))
        else $error("event and error code disagree");

    // field counter stays below four outside the signature
    assert property (@(posedge aclk) disable iff (!aresetn)
        (phase_reg != PH_SIG) |-> (pos_reg[2] == 1'b0))
        else $error("field position out of range");

    // a result is only produced while the output slot can take it
    assert property (@(posedge aclk) disable iff (!aresetn)
        res_emit |-> (!m_tvalid_reg || m_tready))
        else $error("result produced into a full output register");
`endif

endmodule

/* rtl/pngcsc_size_calc.sv */
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// pngcsc_size_calc
// Registered width*height product and the clamped byte size (area*8).
// ---------------------------------------------------------------------------
module pngcsc_size_calc (
    input  logic        aclk,
    input  logic [31:0] img_width,
    input  logic [31:0] img_height,
    output logic [63:0] out_size
);
    logic [63:0] area_reg;

    always_ff @(posedge aclk) begin
        area_reg <= {32'd0, img_width} * {32'd0, img_height};
    end

    // zero area, or area above 2^61-1, reports zero
    assign out_size = ((area_reg != 64'd0) && (area_reg[63:61] == 3'd0)) ?
                      {area_reg[60:0], 3'd0} : 64'd0;

endmodule

/* tb/png_chunk_stream_checker_test.sv */
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// png_chunk_stream_checker_test
// Byte-stream test of the PNG chunk checker. PNG files are built on the fly
// (signature, framed chunks, CRC-32) and fed one byte per beat. A parser
// model inside the bench tracks every accepted byte and queues the result
// beat each finished chunk should produce; a monitor compares each m_ beat
// field by field. Directed files cover signature errors, every chunk kind,
// header capture and size limits, all error codes and restarts. Random
// files follow, mostly well formed, with corrupt and cut-short ones mixed in.
// ---------------------------------------------------------------------------
module png_chunk_stream_checker_test;

    import pngcsc_pkg::*;

    localparam int          QUIET_LIMIT  = 1000;   // cycles with no beat on either side
    localparam int          RANDOM_BYTES = 80;     // parsed bytes in the random part
    localparam logic [63:0] AREA_LIMIT   = 64'h1FFF_FFFF_FFFF_FFFF;
    localparam logic [31:0] TYPE_TEXT    = 32'h7445_5874;  // an ancillary chunk

    typedef logic [7:0] byte_q_t[$];

    // One result beat as the parser model sees it.
    typedef struct packed {
        event_t      ev;
        kind_t       kind;
        logic [31:0] length;
        err_t        err;
        logic [31:0] width;
        logic [31:0] height;
        logic [7:0]  depth;
        logic [7:0]  colour;
        logic [63:0] out_size;
    } chunk_report_t;

    logic                  aclk     = 1'b0;
    logic                  aresetn  = 1'b0;
    logic                  s_tvalid = 1'b0;
    logic                  s_tready;
    logic [IN_DATA_W-1:0]  s_tdata  = '0;   // [7:0] stream_byte
    logic [IN_USER_W-1:0]  s_tuser  = '0;   // [0] file_start
    logic                  m_tvalid;
    logic                  m_tready = 1'b0;
    // [31:0] body_len, [34:32] error_code, [66:35] image_width,
    // [98:67] image_height, [106:99] bit_depth, [114:107] colour_type,
    // [178:115] output_size, [183:179] zero
    logic [OUT_DATA_W-1:0] m_tdata;
    logic [OUT_USER_W-1:0] m_tuser;         // [1:0] event_res, [4:2] chunk_kind

    png_chunk_stream_checker DUT (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser)
    );

    always #1 aclk = ~aclk;

    // ---------------------------------------------------------------------
    // Parser model state; values match the block right after reset
    // (halted until a byte arrives with file_start set).
    // ---------------------------------------------------------------------
    phase_t      pr_phase  = PH_SIG;
    logic [3:0]  pr_pos    = '0;
    logic        pr_sig_bad = 1'b0;
    logic [31:0] pr_len    = '0;
    logic [31:0] pr_left   = '0;
    logic [31:0] pr_type   = '0;
    logic [31:0] pr_crc    = CRC_INIT;
    logic [31:0] pr_rx_crc = '0;
    logic [2:0]  pr_seen   = '0;     // bit0 IHDR, bit1 PLTE, bit2 tRNS
    logic [31:0] pr_w      = '0;
    logic [31:0] pr_h      = '0;
    logic [16:0] pr_fmt    = '0;     // depth, colour, any method byte set
    logic        pr_halted = 1'b1;

    chunk_report_t expected_reports[$];

    int  live_bytes     = 0;   // bytes the parser did not drop
    int  files_sent     = 0;
    int  beats_checked  = 0;
    int  error_beats    = 0;
    int  mismatch_count = 0;
    int  quiet_cycles   = 0;
    int  stall_left     = 0;
    bit  tx_idle        = 1'b1;
    bit  rx_idle        = 1'b1;

    // Reflected CRC-32, one byte, LSB first.
    function automatic logic [31:0] crc_step(logic [31:0] c, logic [7:0] b);
        logic [31:0] r;
        r = c ^ {24'd0, b};
        repeat (8) r = (r >> 1) ^ (CRC_POLY & {32{r[0]}});
        return r;
    endfunction

    function automatic kind_t chunk_kind_of(logic [31:0] t);
        case (t)
            TYPE_IHDR: return KIND_IHDR;
            TYPE_PLTE: return KIND_PLTE;
            TYPE_TRNS: return KIND_TRNS;
            TYPE_IDAT: return KIND_IDAT;
            TYPE_IEND: return KIND_IEND;
            default:   return KIND_OTHER;
        endcase
    endfunction

    function automatic bit depth_colour_supported(logic [16:0] f);
        if (f[16]) return 1'b0;
        case ({f[7:0], f[15:8]})
            {8'd8, 8'd0}, {8'd8, 8'd2}, {8'd8, 8'd3}, {8'd8, 8'd4}, {8'd8, 8'd6},
            {8'd16, 8'd0}, {8'd16, 8'd2}, {8'd16, 8'd4}, {8'd16, 8'd6}:
                return 1'b1;
            default:
                return 1'b0;
        endcase
    endfunction

    function automatic chunk_report_t make_report(event_t ev, kind_t k,
                                                  logic [31:0] len, err_t err);
        chunk_report_t r;
        logic [63:0]   area;
        area       = {32'd0, pr_w} * {32'd0, pr_h};
        r.ev       = ev;
        r.kind     = k;
        r.length   = len;
        r.err      = err;
        r.width    = pr_w;
        r.height   = pr_h;
        r.depth    = pr_fmt[7:0];
        r.colour   = pr_fmt[15:8];
        r.out_size = (area != 0 && area <= AREA_LIMIT) ? area << 3 : 64'd0;
        return r;
    endfunction

    // Advance the parser model by one accepted byte; 1 when a result is due.
    function automatic bit parse_png_byte(input logic [7:0] b, input logic start,
                                          output chunk_report_t r);
        logic [31:0] idx;
        kind_t       k;
        logic [2:0]  flag;
        r = '0;
        if (start) begin
            pr_phase   = PH_SIG;
            pr_pos     = '0;
            pr_sig_bad = 1'b0;
            pr_len     = '0;
            pr_left    = '0;
            pr_type    = '0;
            pr_crc     = CRC_INIT;
            pr_rx_crc  = '0;
            pr_seen    = '0;
            pr_w       = '0;
            pr_h       = '0;
            pr_fmt     = '0;
            pr_halted  = 1'b0;
        end
        if (pr_halted) return 1'b0;
        live_bytes++;
        case (pr_phase)
            PH_SIG: begin
                if (b != SIG_BYTES[pr_pos[2:0]]) pr_sig_bad = 1'b1;
                pr_pos++;
                if (pr_pos < 8) return 1'b0;
                pr_pos = '0;
                if (pr_sig_bad) begin
                    pr_halted = 1'b1;
                    r = make_report(EV_ERROR, KIND_IHDR, 32'd0, ERR_SIGNATURE);
                    return 1'b1;
                end
                pr_phase = PH_LEN;
                return 1'b0;
            end
            PH_LEN: begin
                pr_len = {pr_len[23:0], b};
                pr_pos++;
                if (pr_pos == 4) begin
                    pr_pos   = '0;
                    pr_left  = pr_len;
                    pr_crc   = CRC_INIT;
                    pr_phase = PH_TYPE;
                end
                return 1'b0;
            end
            PH_TYPE: begin
                pr_type = {pr_type[23:0], b};
                pr_crc  = crc_step(pr_crc, b);
                pr_pos++;
                if (pr_pos == 4) begin
                    pr_pos   = '0;
                    pr_phase = (pr_left != 0) ? PH_DATA : PH_CRC;
                end
                return 1'b0;
            end
            PH_DATA: begin
                pr_crc = crc_step(pr_crc, b);
                // only the first header is captured; bytes past 13 are dropped
                if (pr_type == TYPE_IHDR && !pr_seen[0]) begin
                    idx = pr_len - pr_left;
                    if (idx < 4)       pr_w = {pr_w[23:0], b};
                    else if (idx < 8)  pr_h = {pr_h[23:0], b};
                    else if (idx == 8) pr_fmt[7:0] = b;
                    else if (idx == 9) pr_fmt[15:8] = b;
                    else if (idx < 13 && b != 0) pr_fmt[16] = 1'b1;
                end
                pr_left--;
                if (pr_left == 0) begin
                    pr_pos   = '0;
                    pr_phase = PH_CRC;
                end
                return 1'b0;
            end
            default: begin
                pr_rx_crc = {pr_rx_crc[23:0], b};
                pr_pos++;
                if (pr_pos < 4) return 1'b0;
                pr_pos = '0;
                k = chunk_kind_of(pr_type);
                case (k)
                    KIND_IHDR: flag = 3'b001;
                    KIND_PLTE: flag = 3'b010;
                    KIND_TRNS: flag = 3'b100;
                    default:   flag = 3'b000;
                endcase
                pr_halted = 1'b1;
                // CRC goes first, then the ordering and format rules
                if ((pr_crc ^ CRC_INIT) != pr_rx_crc) begin
                    r = make_report(EV_ERROR, k, pr_len, ERR_CRC);
                end else if ((pr_seen & flag) != 0) begin
                    r = make_report(EV_ERROR, k, pr_len, ERR_DUPLICATE);
                end else if (k == KIND_IDAT && !pr_seen[0]) begin
                    r = make_report(EV_ERROR, k, pr_len, ERR_ORDER);
                end else if (k == KIND_IDAT && !depth_colour_supported(pr_fmt)) begin
                    r = make_report(EV_ERROR, k, pr_len, ERR_FORMAT);
                end else if (k == KIND_IEND) begin
                    r = make_report(EV_END, k, pr_len, ERR_NONE);
                end else begin
                    pr_halted = 1'b0;
                    pr_seen   = pr_seen | flag;
                    pr_phase  = PH_LEN;
                    pr_crc    = CRC_INIT;
                    r = make_report(EV_CHUNK, k, pr_len, ERR_NONE);
                end
                return 1'b1;
            end
        endcase
    endfunction

    // ---------------------------------------------------------------------
    // Byte sender: optional idle burst, then hold the beat until taken.
    // ---------------------------------------------------------------------
    task automatic send_byte(input logic [7:0] b, input logic start);
        chunk_report_t rep;
        if (tx_idle && $urandom_range(0, 7) == 0) begin
            s_tvalid <= 1'b0;
            repeat ($urandom_range(1, 16)) @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= b;
        s_tuser  <= start;
        @(posedge aclk);
        while (!s_tready) @(posedge aclk);
        if (parse_png_byte(b, start, rep)) expected_reports.push_back(rep);
    endtask

    // Stop sending until every queued result has come out.
    task automatic drain_results();
        s_tvalid <= 1'b0;
        @(posedge aclk);
        while (expected_reports.size() != 0) @(posedge aclk);
    endtask

    // Eight signature bytes; bad_at >= 0 corrupts that byte.
    task automatic send_signature(input int bad_at);
        logic [7:0] b;
        files_sent++;
        for (int i = 0; i < 8; i++) begin
            b = SIG_BYTES[i];
            if (i == bad_at) b = b ^ 8'($urandom_range(1, 255));
            send_byte(b, i == 0);
        end
    endtask

    // Length, type, data and CRC; bad_crc flips one CRC bit.
    task automatic send_chunk(input logic [31:0] ctype, input byte_q_t body,
                              input bit bad_crc);
        logic [31:0] len;
        logic [31:0] crc;
        len = body.size();
        crc = CRC_INIT;
        for (int i = 3; i >= 0; i--) send_byte(len[8*i +: 8], 1'b0);
        for (int i = 3; i >= 0; i--) begin
            send_byte(ctype[8*i +: 8], 1'b0);
            crc = crc_step(crc, ctype[8*i +: 8]);
        end
        foreach (body[i]) begin
            send_byte(body[i], 1'b0);
            crc = crc_step(crc, body[i]);
        end
        crc = ~crc;
        if (bad_crc) crc = crc ^ (32'd1 << $urandom_range(0, 31));
        for (int i = 3; i >= 0; i--) send_byte(crc[8*i +: 8], 1'b0);
    endtask

    function automatic byte_q_t random_body(input int n);
        byte_q_t q;
        repeat (n) q.push_back(8'($urandom()));
        return q;
    endfunction

    // 13-byte header; methods = compression, filter, interlace
    function automatic byte_q_t header_bytes(input logic [31:0] w, input logic [31:0] h,
                                             input logic [7:0] d, input logic [7:0] c,
                                             input logic [23:0] methods);
        byte_q_t q;
        for (int i = 3; i >= 0; i--) q.push_back(w[8*i +: 8]);
        for (int i = 3; i >= 0; i--) q.push_back(h[8*i +: 8]);
        q.push_back(d);
        q.push_back(c);
        for (int i = 2; i >= 0; i--) q.push_back(methods[8*i +: 8]);
        return q;
    endfunction

    function automatic logic [31:0] random_dimension();
        case ($urandom_range(0, 4))
            0:       return 32'd0;
            1:       return 32'hFFFF_FFFF;
            2:       return $urandom();
            default: return $urandom_range(1, 4096);
        endcase
    endfunction

    function automatic byte_q_t random_header();
        byte_q_t     q;
        logic [7:0]  d;
        logic [7:0]  c;
        logic [23:0] m;
        if ($urandom_range(0, 3) != 0) begin
            d = $urandom_range(0, 1) ? 8'd8 : 8'd16;
            case ($urandom_range(0, 4))
                0:       c = 8'd0;
                1:       c = 8'd2;
                2:       c = 8'd3;
                3:       c = 8'd4;
                default: c = 8'd6;
            endcase
        end else begin
            d = $urandom_range(0, 1) ? 8'($urandom()) : 8'(1 << $urandom_range(0, 5));
            c = 8'($urandom_range(0, 7));
        end
        m = '0;
        if ($urandom_range(0, 7) == 0) m = 24'($urandom_range(1, 255)) << (8 * $urandom_range(0, 2));
        q = header_bytes(random_dimension(), random_dimension(), d, c, m);
        // now and then a short or padded header
        case ($urandom_range(0, 11))
            0:       repeat ($urandom_range(1, 13)) void'(q.pop_back());
            1:       repeat ($urandom_range(1, 7)) q.push_back(8'($urandom()));
            default: ;
        endcase
        return q;
    endfunction

    // Mostly a sane file; corrupt signature, bad CRC, odd chunk order,
    // garbage tail and missing end chunk show up at low rates.
    task automatic send_random_file();
        logic [31:0] ctype;
        byte_q_t     body;
        send_signature(($urandom_range(0, 11) == 0) ? $urandom_range(0, 7) : -1);
        if ($urandom_range(0, 9) != 0)
            send_chunk(TYPE_IHDR, random_header(), $urandom_range(0, 15) == 0);
        repeat ($urandom_range(1, 6)) begin
            case ($urandom_range(0, 9))
                0:       ctype = TYPE_IHDR;
                1:       ctype = TYPE_PLTE;
                2:       ctype = TYPE_TRNS;
                3, 4, 5: ctype = TYPE_IDAT;
                6:       ctype = TYPE_TEXT;
                7:       ctype = $urandom();
                default: ctype = TYPE_IDAT ^ (32'd1 << $urandom_range(0, 31));
            endcase
            body = (ctype == TYPE_IHDR) ? random_header() : random_body($urandom_range(0, 16));
            send_chunk(ctype, body, $urandom_range(0, 15) == 0);
        end
        if ($urandom_range(0, 5) == 0) begin
            // cut short: stray bytes, the next file start restarts the parser
            repeat ($urandom_range(1, 12)) send_byte(8'($urandom()), 1'b0);
        end else begin
            send_chunk(TYPE_IEND, random_body($urandom_range(0, 3) == 0), $urandom_range(0, 15) == 0);
        end
        if ($urandom_range(0, 5) == 0) drain_results();
    endtask

    // ---------------------------------------------------------------------
    // Tests
    // ---------------------------------------------------------------------

    // After reset the block is halted: bytes without file_start are dropped.
    task automatic test_halted_input_ignored();
        repeat (6) send_byte(8'($urandom()), 1'b0);
    endtask

    // Signature mismatch on the first byte, the last byte and one in between.
    task automatic test_signature_checks();
        send_signature(0);
        send_signature(7);
        send_signature($urandom_range(1, 6));
        repeat (3) send_byte(8'($urandom()), 1'b0);   // halted again
    endtask

    // One file with every chunk kind, a zero-length chunk and the end chunk.
    task automatic test_complete_file();
        send_signature(-1);
        send_chunk(TYPE_IHDR, header_bytes(32'd1, 32'd1, 8'd8, 8'd6, 24'd0), 1'b0);
        drain_results();   // sender holds off until the queue is empty
        send_chunk(TYPE_PLTE, random_body(3), 1'b0);
        send_chunk(TYPE_TRNS, random_body(1), 1'b0);
        send_chunk(TYPE_TEXT, random_body(1), 1'b0);
        send_chunk(TYPE_IDAT, random_body(2), 1'b0);
        send_chunk(TYPE_IDAT, random_body(0), 1'b0);
        send_chunk(TYPE_IEND, random_body(0), 1'b0);
        send_byte(8'hFF, 1'b0);                       // dropped after the end
    endtask

    // Size boundaries and short / padded headers.
    task automatic test_header_capture();
        logic [31:0] widths  [5];
        logic [31:0] heights [5];
        byte_q_t     hdr;
        // zero area, overflow, just past the limit, just inside it, smallest
        widths  = '{32'd0, 32'hFFFF_FFFF, 32'h8000_0000, 32'h8000_0000, 32'd1};
        heights = '{32'd5, 32'hFFFF_FFFF, 32'h4000_0000, 32'h3FFF_FFFF, 32'd1};
        for (int i = 0; i < 5; i++) begin
            send_signature(-1);
            send_chunk(TYPE_IHDR, header_bytes(widths[i], heights[i], 8'd8, 8'd2, 24'd0), 1'b0);
        end
        // header cut to 5 bytes: depth stays zero, image data is refused
        hdr = header_bytes(32'h0102_0304, 32'h0506_0708, 8'd8, 8'd2, 24'd0);
        repeat (8) void'(hdr.pop_back());
        send_signature(-1);
        send_chunk(TYPE_IHDR, hdr, 1'b0);
        send_chunk(TYPE_IDAT, random_body(2), 1'b0);
        // padded header: bytes past the 13th do not touch the capture
        hdr = header_bytes(32'd33, 32'd17, 8'd16, 8'd4, 24'd0);
        repeat (7) hdr.push_back(8'($urandom_range(1, 255)));
        send_signature(-1);
        send_chunk(TYPE_IHDR, hdr, 1'b0);
        send_chunk(TYPE_IDAT, random_body(3), 1'b0);
        send_chunk(TYPE_IEND, random_body(0), 1'b0);
    endtask

    // Every error code past the signature.
    task automatic test_chunk_errors();
        byte_q_t hdr;
        hdr = header_bytes(32'd640, 32'd480, 8'd8, 8'd2, 24'd0);
        // bad CRC on the header, then on an ancillary chunk
        send_signature(-1);
        send_chunk(TYPE_IHDR, hdr, 1'b1);
        repeat (3) send_byte(8'($urandom()), 1'b0);
        send_signature(-1);
        send_chunk(TYPE_TEXT, random_body(3), 1'b1);
        // repeated header keeps the first values
        send_signature(-1);
        send_chunk(TYPE_IHDR, header_bytes(32'd7, 32'd9, 8'd16, 8'd6, 24'd0), 1'b0);
        send_chunk(TYPE_IHDR, hdr, 1'b0);
        // repeated palette and transparency
        send_signature(-1);
        send_chunk(TYPE_PLTE, random_body(2), 1'b0);
        send_chunk(TYPE_PLTE, random_body(2), 1'b0);
        send_signature(-1);
        send_chunk(TYPE_TRNS, random_body(1), 1'b0);
        send_chunk(TYPE_TRNS, random_body(1), 1'b0);
        // image data with no header yet
        send_signature(-1);
        send_chunk(TYPE_IDAT, random_body(4), 1'b0);
        // unsupported depth, depth/colour pair and interlace method
        send_signature(-1);
        send_chunk(TYPE_IHDR, header_bytes(32'd4, 32'd4, 8'd4, 8'd0, 24'd0), 1'b0);
        send_chunk(TYPE_IDAT, random_body(1), 1'b0);
        send_signature(-1);
        send_chunk(TYPE_IHDR, header_bytes(32'd4, 32'd4, 8'd16, 8'd3, 24'd0), 1'b0);
        send_chunk(TYPE_IDAT, random_body(1), 1'b0);
        send_signature(-1);
        send_chunk(TYPE_IHDR, header_bytes(32'd4, 32'd4, 8'd8, 8'd6, 24'd1), 1'b0);
        send_chunk(TYPE_IDAT, random_body(1), 1'b0);
    endtask

    // file_start in the middle of a signature and of a huge chunk.
    task automatic test_restart_mid_file();
        send_byte(SIG_BYTES[0], 1'b1);
        send_byte(SIG_BYTES[1], 1'b0);
        send_byte(8'h00, 1'b0);
        send_signature(-1);
        send_chunk(TYPE_IHDR, header_bytes(32'd2, 32'd3, 8'd8, 8'd0, 24'd0), 1'b0);
        repeat (4) send_byte(8'hFF, 1'b0);            // largest length
        for (int i = 3; i >= 0; i--) send_byte(TYPE_IDAT[8*i +: 8], 1'b0);
        repeat (5) send_byte(8'($urandom()), 1'b0);
        send_signature(-1);
        send_chunk(TYPE_IHDR, header_bytes(32'd2, 32'd3, 8'd8, 8'd0, 24'd0), 1'b0);
        send_chunk(TYPE_IDAT, random_body(6), 1'b0);
        send_chunk(TYPE_IEND, random_body(0), 1'b0);
    endtask

    task automatic test_random_files();
        int target;
        target = live_bytes + RANDOM_BYTES;
        while (live_bytes < target) begin
            // idling comes and goes per file so some files run with none
            tx_idle = ($urandom_range(0, 3) != 0);
            rx_idle = ($urandom_range(0, 3) != 0);
            send_random_file();
        end
    endtask

    // Closing stretch at full rate on both sides.
    task automatic test_back_to_back_files();
        tx_idle = 1'b0;
        rx_idle = 1'b0;
        repeat (2) send_random_file();
    endtask

    // ---------------------------------------------------------------------
    // Receiver stalls: m_tready is dropped at random while rx_idle is set.
    // ---------------------------------------------------------------------
    always @(posedge aclk) begin
        if (!aresetn) begin
            m_tready   <= 1'b1;
            stall_left <= 0;
        end else if (stall_left != 0) begin
            stall_left <= stall_left - 1;
            m_tready   <= (stall_left == 1);
        end else if (rx_idle && $urandom_range(0, 9) == 0) begin
            stall_left <= $urandom_range(1, 16);
            m_tready   <= 1'b0;
        end else begin
            m_tready   <= 1'b1;
        end
    end

    task automatic flag_mismatch(input string field, input logic [63:0] got,
                                 input logic [63:0] want);
        $display("%0t: %s mismatch, got 0x%0h, expected 0x%0h", $time, field, got, want);
        mismatch_count++;
    endtask

    // Result monitor: each m_ beat against the oldest queued report.
    always @(posedge aclk) begin
        chunk_report_t want;
        if (aresetn && m_tvalid && m_tready) begin
            if (expected_reports.size() == 0) begin
                flag_mismatch("beat with nothing queued", 64'(m_tuser), 64'd0);
            end else begin
                want = expected_reports.pop_front();
                beats_checked++;
                if (want.ev == EV_ERROR) error_beats++;
                if (m_tuser[1:0] !== want.ev)
                    flag_mismatch("event_res", 64'(m_tuser[1:0]), 64'(want.ev));
                if (m_tuser[4:2] !== want.kind)
                    flag_mismatch("chunk_kind", 64'(m_tuser[4:2]), 64'(want.kind));
                if (m_tdata[31:0] !== want.length)
                    flag_mismatch("body_len", 64'(m_tdata[31:0]), 64'(want.length));
                if (m_tdata[34:32] !== want.err)
                    flag_mismatch("error_code", 64'(m_tdata[34:32]), 64'(want.err));
                if (m_tdata[66:35] !== want.width)
                    flag_mismatch("image_width", 64'(m_tdata[66:35]), 64'(want.width));
                if (m_tdata[98:67] !== want.height)
                    flag_mismatch("image_height", 64'(m_tdata[98:67]), 64'(want.height));
                if (m_tdata[106:99] !== want.depth)
                    flag_mismatch("bit_depth", 64'(m_tdata[106:99]), 64'(want.depth));
                if (m_tdata[114:107] !== want.colour)
                    flag_mismatch("colour_type", 64'(m_tdata[114:107]), 64'(want.colour));
                if (m_tdata[178:115] !== want.out_size)
                    flag_mismatch("output_size", m_tdata[178:115], want.out_size);
                if (m_tdata[183:179] !== 5'd0)
                    flag_mismatch("tdata pad", 64'(m_tdata[183:179]), 64'd0);
            end
        end
    end

    // Watchdog: too long without a beat on either side ends the run.
    always @(posedge aclk) begin
        if (!aresetn || (s_tvalid && s_tready) || (m_tvalid && m_tready))
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles == QUIET_LIMIT) begin
            $display("Verification failed");
            $finish;
        end
    end

    initial begin
        repeat (9) @(posedge aclk);
        aresetn <= 1'b1;

        test_halted_input_ignored();
        test_signature_checks();
        test_complete_file();
        test_header_capture();
        test_chunk_errors();
        test_restart_mid_file();
        test_random_files();
        test_back_to_back_files();

        drain_results();
        repeat (8) @(posedge aclk);

        $display("Run: %0d files, %0d parsed bytes, %0d result beats checked (%0d errors)",
                 files_sent, live_bytes, beats_checked, error_beats);
        if (mismatch_count == 0) begin
            $display("Verification passed");
        end else begin
            $display("Verification failed");
        end
        $finish;
    end

endmodule

/* sim.f */
rtl/pngcsc_pkg.sv
rtl/pngcsc_size_calc.sv
rtl/png_chunk_stream_checker.sv
tb/png_chunk_stream_checker_test.sv
